/* sv/ncqd_pkg.sv */
// ncqd_pkg: shared types and constants of the ntsc chroma quadrature demodulator
// used by every module of the block; depends on nothing

package ncqd_pkg;

	// frame geometry limits, pixels outside them never demodulate
	localparam int unsigned MaxWidth = 1024;
	localparam int unsigned MaxLines = 1024;

	// field widths
	localparam int unsigned SampleW = 16;
	localparam int unsigned ColW = 10;
	localparam int unsigned LineW = 10;
	localparam int unsigned IdW = 3;
	localparam int unsigned ChromaW = 17;
	localparam int unsigned CoefW = 17;
	localparam int unsigned ProdW = ChromaW + CoefW;
	localparam int unsigned SumW = ProdW + 1;
	localparam int unsigned FracBits = 14;
	localparam int unsigned OutW = 20;
	localparam int unsigned InDataW = 64;
	localparam int unsigned OutDataW = 56;

	// config port
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 17;
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_START = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_END = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FIRST_LINE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LAST_LINE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_COEF_SIN = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_COEF_COS = 3'd5;

	localparam logic signed [CoefW-1:0] CoefCosReset = 17'sd16384;

	// phase ids that count as positive line phase
	localparam logic [IdW-1:0] PHASE_ID_ONE = 3'd1;
	localparam logic [IdW-1:0] PHASE_ID_FOUR = 3'd4;

	// queue between front and back
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW = $clog2(QueueDepth);

	typedef struct packed {
		logic [9:0]  active_start;
		logic [10:0] active_end;
		logic [9:0]  first_line;
		logic [10:0] last_line;
		logic signed [CoefW-1:0] coef_sin;
		logic signed [CoefW-1:0] coef_cos;
	} ncqd_cfg_t;

	// one classified pixel: what the back end must do with it
	typedef struct packed {
		logic [SampleW-1:0]        luma;
		logic                      active;
		logic                      clear;   // start of span, zero both held values
		logic                      sel_i;   // write held i, else held q
		logic signed [ChromaW-1:0] value;   // signed chroma already steered
	} ncqd_item_t;

endpackage

/* sv/ncqd_front.sv */
// ncqd_front: accepts composite pixels, decides window, line phase and steering
// depends on ncqd_pkg

module ncqd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ncqd_pkg::ncqd_cfg_t           cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ncqd_pkg::InDataW-1:0]  s_tdata,
	output logic                          item_valid,
	input  logic                          item_ready,
	output ncqd_pkg::ncqd_item_t          item
);
	import ncqd_pkg::*;

	logic [SampleW-1:0] composite;
	logic [SampleW-1:0] luma;
	logic [ColW-1:0]    column;
	logic [LineW-1:0]   frame_line;
	logic [IdW-1:0]     id_even;
	logic [IdW-1:0]     id_odd;
	logic [IdW-1:0]     id_sel;
	logic               id_pos;
	logic               line_pos;
	logic               line_ok;
	logic               col_ok;
	logic               active;
	logic               negate;
	logic signed [ChromaW-1:0] chroma;
	logic signed [ChromaW-1:0] steered;
	ncqd_item_t         next_item;
	logic               vld_s1;
	ncqd_item_t         item_s1;

	assign composite  = s_tdata[15:0];
	assign luma       = s_tdata[31:16];
	assign column     = s_tdata[41:32];
	assign frame_line = s_tdata[51:42];
	assign id_even    = s_tdata[54:52];
	assign id_odd     = s_tdata[57:55];

	always_comb begin
		line_ok = (frame_line >= cfg.first_line)
			&& ({1'b0, frame_line} < cfg.last_line)
			&& (13'(frame_line) < 13'(MaxLines));
		col_ok = (column >= cfg.active_start)
			&& ({1'b0, column} < cfg.active_end)
			&& (13'(column) < 13'(MaxWidth));
		active = line_ok && col_ok;
	end

	// even frame lines belong to the first field; phase flips on odd field lines
	always_comb begin
		id_sel = frame_line[0] ? id_odd : id_even;
		id_pos = (id_sel == PHASE_ID_ONE) || (id_sel == PHASE_ID_FOUR);
		line_pos = frame_line[1] ? !id_pos : id_pos;
	end

	// column phases 1 and 2 invert the sign set by the line phase
	always_comb begin
		chroma = $signed({1'b0, composite}) - $signed({1'b0, luma});
		negate = line_pos ^ (column[0] ^ column[1]);
		steered = negate ? -chroma : chroma;
	end

	always_comb begin
		next_item.luma   = luma;
		next_item.active = active;
		next_item.clear  = active && (column == cfg.active_start);
		next_item.sel_i  = column[0];
		next_item.value  = steered;
	end

	assign s_tready = !vld_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= next_item;
		end
	end

	assign item_valid = vld_s1;
	assign item = item_s1;

endmodule

/* sv/ncqd_queue.sv */
// ncqd_queue: short first-in first-out queue of classified pixels
// depends on ncqd_pkg

module ncqd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ncqd_pkg::ncqd_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ncqd_pkg::ncqd_item_t pop_item
);
	import ncqd_pkg::*;

	ncqd_item_t           slot_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != (QueuePtrW+1)'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* sv/ncqd_back.sv */
// ncqd_back: held i/q registers, rotation into u/v, rounding and output register
// depends on ncqd_pkg

module ncqd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ncqd_pkg::ncqd_cfg_t           cfg,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  ncqd_pkg::ncqd_item_t          item,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ncqd_pkg::OutDataW-1:0] m_tdata
);
	import ncqd_pkg::*;

	logic                       adv;
	logic                       take;
	logic signed [ChromaW-1:0]  held_i_q;
	logic signed [ChromaW-1:0]  held_q_q;
	logic signed [ChromaW-1:0]  next_i;
	logic signed [ChromaW-1:0]  next_q;

	logic                       vld_s2, vld_s3, vld_s4;
	logic                       act_s2, act_s3;
	logic [SampleW-1:0]         luma_s2, luma_s3, luma_s4;
	logic signed [ChromaW-1:0]  hi_s2, hq_s2;
	logic signed [ProdW-1:0]    p_si_s3, p_sq_s3, p_ci_s3, p_cq_s3;
	logic signed [OutW-1:0]     u_s4, v_s4;

	logic signed [SumW-1:0]     sum_u, sum_v;
	logic signed [OutW-1:0]     u_next, v_next;

	function automatic logic signed [OutW-1:0] round_sat(input logic signed [SumW-1:0] s);
		logic signed [SumW-1:0]          t;
		logic signed [SumW-FracBits-1:0] r;
		t = s + SumW'(1 << (FracBits - 1));
		r = t[SumW-1:FracBits];
		if (r[SumW-FracBits-1] != r[OutW-1]) begin
			round_sat = r[SumW-FracBits-1] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
		end else begin
			round_sat = r[OutW-1:0];
		end
	endfunction

	// whole back pipeline stalls together on the output register
	assign adv        = !m_tvalid || m_tready;
	assign item_ready = adv;
	assign take       = adv && item_valid;

	always_comb begin
		next_i = item.clear ? '0 : held_i_q;
		next_q = item.clear ? '0 : held_q_q;
		if (item.sel_i) begin
			next_i = item.value;
		end else begin
			next_q = item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_i_q <= '0;
			held_q_q <= '0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
		end else if (adv) begin
			if (item_valid && item.active) begin
				held_i_q <= next_i;
				held_q_q <= next_q;
			end
			vld_s2 <= item_valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_s2  <= item.active;
			luma_s2 <= item.luma;
			hi_s2   <= next_i;
			hq_s2   <= next_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3  <= act_s2;
			luma_s3 <= luma_s2;
			p_si_s3 <= cfg.coef_sin * hi_s2;
			p_sq_s3 <= cfg.coef_sin * hq_s2;
			p_ci_s3 <= cfg.coef_cos * hi_s2;
			p_cq_s3 <= cfg.coef_cos * hq_s2;
		end
	end

	always_comb begin
		sum_u  = SumW'(p_cq_s3) - SumW'(p_si_s3);
		sum_v  = SumW'(p_ci_s3) + SumW'(p_sq_s3);
		u_next = act_s3 ? round_sat(sum_u) : '0;
		v_next = act_s3 ? round_sat(sum_v) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			luma_s4 <= luma_s3;
			u_s4    <= u_next;
			v_s4    <= v_next;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {v_s4, u_s4, luma_s4};

endmodule

/* sv/ntsc_chroma_quadrature_demod.sv */
// ntsc_chroma_quadrature_demod: top level of the 4fsc chroma demodulator
// holds the config registers; depends on ncqd_pkg, ncqd_front, ncqd_queue, ncqd_back

// One 4fsc composite pixel goes in per transaction and one result (pass-through
// luma, u and v) comes out per transaction, in order. The block sustains one pixel
// per clock when nothing stalls. A pixel goes from its input transaction into the
// classifier register, from there into the four-entry queue, out of the queue into
// the held i/q update, through the registered 17x17 multiplies, and through the
// round/saturate stage into the output register. Chroma is composite minus luma,
// sign-flipped by the ntsc line phase (field parity from frame line bit 0, field
// line parity from bit 1, phase id 1 or 4 counts positive) and steered by column
// mod 4 into the held i or q value, which both clear at the first column of the
// active span. u and v are the rotation by coef_sin/coef_cos in Q2.14, rounded half
// up and saturated to 20 bits, and read zero outside the window of columns
// [active_start, active_end) and frame lines [first_line, last_line). The front
// stalls only when the queue is full and the back stalls only on the output
// register, so a short downstream stall does not stop input at once. Config
// registers are written through cfg_we / cfg_index / cfg_data and must only be
// changed while no pixel is in flight.

module ntsc_chroma_quadrature_demod (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic [ncqd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ncqd_pkg::CfgDataW-1:0]  cfg_data,
	// pixel input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// composite[15:0], luma[31:16], column[41:32], frame_line[51:42],
	// first_phase_id[54:52], second_phase_id[57:55], zero fill [63:58]
	input  logic [ncqd_pkg::InDataW-1:0]   s_tdata,
	// result output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// luma_out[15:0], u_out[35:16], v_out[55:36]
	output logic [ncqd_pkg::OutDataW-1:0]  m_tdata
);
	import ncqd_pkg::*;

	ncqd_cfg_t  cfg_q;
	logic       fr_valid;
	logic       fr_ready;
	ncqd_item_t fr_item;
	logic       q_valid;
	logic       q_ready;
	ncqd_item_t q_item;

	// config registers, written one at a time; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_start <= '0;
			cfg_q.active_end   <= '0;
			cfg_q.first_line   <= '0;
			cfg_q.last_line    <= '0;
			cfg_q.coef_sin     <= '0;
			cfg_q.coef_cos     <= CoefCosReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_START: cfg_q.active_start <= cfg_data[9:0];
				REG_ACTIVE_END:   cfg_q.active_end   <= cfg_data[10:0];
				REG_FIRST_LINE:   cfg_q.first_line   <= cfg_data[9:0];
				REG_LAST_LINE:    cfg_q.last_line    <= cfg_data[10:0];
				REG_COEF_SIN:     cfg_q.coef_sin     <= $signed(cfg_data);
				REG_COEF_COS:     cfg_q.coef_cos     <= $signed(cfg_data);
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// front: window test, line phase, chroma sign and steering
	ncqd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	// decoupling queue between classifier and arithmetic
	ncqd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// back: held i/q, rotation, rounding, output register
	ncqd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// a stalled output register must freeze the back end, so nothing leaves the queue
	a_back_stall_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(q_valid && q_ready))
		else $error("queue popped while output register stalled");

	// input only backs up once the queue is full
	a_front_stall_needs_full_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (fr_valid && !fr_ready))
		else $error("front stalled with room in the queue");

	// a write to the cosine coefficient lands in the next cycle
	a_coef_cos_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == REG_COEF_COS)) |=> (cfg_q.coef_cos == $past($signed(cfg_data))))
		else $error("coef_cos write lost");

endmodule

/* test/ntsc_chroma_quadrature_demod_tb.sv */
`timescale 1ns / 100ps
// ntsc_chroma_quadrature_demod_tb: self-checking bench for the 4fsc chroma demodulator
// predicts luma/u/v for every pixel and checks each output transaction in order
// depends on ncqd_pkg and ntsc_chroma_quadrature_demod

module ntsc_chroma_quadrature_demod_tb;
	import ncqd_pkg::*;

	// input transaction, composite in the low bits as on s_tdata
	typedef struct packed {
		logic [IdW-1:0]     second_id;
		logic [IdW-1:0]     first_id;
		logic [LineW-1:0]   frame_line;
		logic [ColW-1:0]    column;
		logic [SampleW-1:0] luma;
		logic [SampleW-1:0] composite;
	} pixel_t;

	// output transaction, laid out as on m_tdata
	typedef struct packed {
		logic signed [OutW-1:0] v;
		logic signed [OutW-1:0] u;
		logic [SampleW-1:0]     luma;
	} uv_result_t;

	localparam longint OutMax = (longint'(1) <<< (OutW - 1)) - 1;
	localparam longint OutMin = -OutMax - 1;
	localparam int StallCycles = 200;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// composite, luma, column, frame_line, first_phase_id, second_phase_id, zero fill
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// luma_out, u_out, v_out
	logic [OutDataW-1:0] m_tdata;

	// bench copy of the window/coef registers and of the held chroma pair
	ncqd_cfg_t                 win_cfg;
	logic signed [ChromaW-1:0] i_hold;
	logic signed [ChromaW-1:0] q_hold;

	uv_result_t pending_uv[$];
	int err_count = 0;

	// idle controls; src_idle belongs to the sending process
	bit src_idle = 1'b0;
	bit snk_idle = 1'b0;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int snk_gap = 0;

	always #5 clk = ~clk;

	ntsc_chroma_quadrature_demod u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	// Q14 sum to output: round half up, then clamp to the 20 bit range
	function automatic logic signed [OutW-1:0] round_sat(input longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
		if (q > OutMax) q = OutMax;
		else if (q < OutMin) q = OutMin;
		return q[OutW-1:0];
	endfunction

	// predicts one pixel and advances the held i/q pair
	function automatic uv_result_t demod_pixel(input pixel_t px);
		uv_result_t r;
		logic [IdW-1:0] id;
		logic phase_pos;
		logic active;
		logic signed [ChromaW-1:0] chroma;
		longint su;
		longint sv;
		r.luma = px.luma;
		r.u = '0;
		r.v = '0;
		active = px.frame_line >= win_cfg.first_line && px.frame_line < win_cfg.last_line &&
			px.frame_line < MaxLines && px.column >= win_cfg.active_start &&
			px.column < win_cfg.active_end && px.column < MaxWidth;
		if (active) begin
			// odd frame lines belong to the second field
			id = px.frame_line[0] ? px.second_id : px.first_id;
			phase_pos = (id == PHASE_ID_ONE) || (id == PHASE_ID_FOUR);
			// odd line within the field flips the phase
			if (px.frame_line[1]) phase_pos = !phase_pos;
			chroma = $signed({1'b0, px.composite}) - $signed({1'b0, px.luma});
			if (phase_pos) chroma = -chroma;
			// first column of the span starts from a clean pair
			if (px.column == win_cfg.active_start) begin
				i_hold = '0;
				q_hold = '0;
			end
			case (px.column[1:0])
				2'd0: q_hold = chroma;
				2'd1: i_hold = -chroma;
				2'd2: q_hold = -chroma;
				default: i_hold = chroma;
			endcase
			su = -longint'(win_cfg.coef_sin) * longint'(i_hold) +
				longint'(win_cfg.coef_cos) * longint'(q_hold);
			sv = longint'(win_cfg.coef_cos) * longint'(i_hold) +
				longint'(win_cfg.coef_sin) * longint'(q_hold);
			r.u = round_sat(su);
			r.v = round_sat(sv);
		end
		return r;
	endfunction

	function automatic pixel_t mk_pixel(input int unsigned line, input int unsigned col,
		input int unsigned comp, input int unsigned luma, input int unsigned id_even,
		input int unsigned id_odd);
		pixel_t px;
		px.frame_line = LineW'(line);
		px.column = ColW'(col);
		px.composite = SampleW'(comp);
		px.luma = SampleW'(luma);
		px.first_id = IdW'(id_even);
		px.second_id = IdW'(id_odd);
		return px;
	endfunction

	function automatic logic signed [CoefW-1:0] random_coef();
		case ($urandom_range(0, 7))
			0: return 17'h10000;   // most negative
			1: return 17'h0FFFF;   // most positive
			2: return '0;
			3: return CoefW'($urandom_range(0, (1 << CoefW) - 1));
			default: return CoefW'(int'($urandom_range(0, 40000)) - 20000);
		endcase
	endfunction

	// small windows keep scanlines short; some at the top edges, some empty
	function automatic ncqd_cfg_t random_settings();
		ncqd_cfg_t s;
		int unsigned lo;
		int unsigned hi;
		lo = ($urandom_range(0, 4) == 0) ? $urandom_range(MaxWidth - 24, MaxWidth - 1)
			: $urandom_range(0, MaxWidth - 1);
		hi = lo + $urandom_range(1, 40);
		if (hi > MaxWidth) hi = MaxWidth;
		if ($urandom_range(0, 11) == 0) hi = $urandom_range(0, lo);
		s.active_start = ColW'(lo);
		s.active_end = 11'(hi);
		lo = ($urandom_range(0, 4) == 0) ? $urandom_range(MaxLines - 4, MaxLines - 1)
			: $urandom_range(0, MaxLines - 1);
		hi = lo + $urandom_range(1, 4);
		if (hi > MaxLines) hi = MaxLines;
		if ($urandom_range(0, 11) == 0) hi = $urandom_range(0, lo);
		if ($urandom_range(0, 5) == 0) begin
			lo = 0;
			hi = MaxLines;
		end
		s.first_line = LineW'(lo);
		s.last_line = 11'(hi);
		s.coef_sin = random_coef();
		s.coef_cos = random_coef();
		return s;
	endfunction

	// writes all six registers back to back, block must be idle
	task automatic apply_settings(input ncqd_cfg_t s);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE_START;
		cfg_data <= CfgDataW'(s.active_start);
		@(posedge clk);
		cfg_index <= REG_ACTIVE_END;
		cfg_data <= CfgDataW'(s.active_end);
		@(posedge clk);
		cfg_index <= REG_FIRST_LINE;
		cfg_data <= CfgDataW'(s.first_line);
		@(posedge clk);
		cfg_index <= REG_LAST_LINE;
		cfg_data <= CfgDataW'(s.last_line);
		@(posedge clk);
		cfg_index <= REG_COEF_SIN;
		cfg_data <= s.coef_sin;
		@(posedge clk);
		cfg_index <= REG_COEF_COS;
		cfg_data <= s.coef_cos;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_cfg = s;
	endtask

	// one input transaction; tvalid stays up for a following pixel
	task automatic send_pixel(input pixel_t px);
		int gap;
		gap = src_idle ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= InDataW'(px);
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_uv.push_back(demod_pixel(px));
	endtask

	task automatic wait_drained();
		while (pending_uv.size() != 0) @(posedge clk);
	endtask

	// called right after an accepted transaction
	task automatic close_burst();
		s_tvalid <= 1'b0;
		wait_drained();
	endtask

	// consecutive columns over the span plus a little margin on each side;
	// a broken one starts mid-span and drops columns
	task automatic send_scanline(input ncqd_cfg_t s, input bit broken, output int n);
		int unsigned line;
		int unsigned col_lo;
		int unsigned col_hi;
		int unsigned id_a;
		int unsigned id_b;
		int unsigned col;
		n = 0;
		if (s.last_line > s.first_line && $urandom_range(0, 5) != 0)
			line = $urandom_range(s.first_line, s.last_line - 1);
		else if ($urandom_range(0, 1) == 0)
			line = (s.last_line > MaxLines - 1) ? MaxLines - 1 : s.last_line;
		else
			line = $urandom_range(0, MaxLines - 1);
		col_lo = (s.active_start > 2) ? s.active_start - 2 : 0;
		col_hi = (s.active_end > s.active_start) ? s.active_end + 1 : s.active_start + 6;
		if (col_hi > MaxWidth - 1) col_hi = MaxWidth - 1;
		if (broken) col_lo = $urandom_range(col_lo, col_hi);
		id_a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
		id_b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
		for (col = col_lo; col <= col_hi; col++) begin
			if (broken && col != col_lo && $urandom_range(0, 2) == 0) continue;
			send_pixel(mk_pixel(line, col, $urandom_range(0, 65535),
				$urandom_range(0, 65535), id_a, id_b));
			n++;
		end
	endtask

	task automatic send_noise(input int count, output int n);
		n = 0;
		repeat (count) begin
			send_pixel(mk_pixel($urandom_range(0, MaxLines - 1), $urandom_range(0, MaxWidth - 1),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 7),
				$urandom_range(0, 7)));
			n++;
		end
	endtask

	// reset values leave the window empty: u and v must read zero
	task automatic test_reset_window();
		send_pixel(mk_pixel(0, 0, 65535, 0, PHASE_ID_ONE, PHASE_ID_ONE));
		send_pixel(mk_pixel(1, 1, 0, 65535, 2, 3));
		send_pixel(mk_pixel(1023, 1023, 65535, 65535, 7, 0));
		close_burst();
	endtask

	// whole frame active, extreme coefficients, extreme samples, every phase id
	task automatic test_full_window();
		ncqd_cfg_t s;
		s.active_start = '0;
		s.active_end = 11'(MaxWidth);
		s.first_line = '0;
		s.last_line = 11'(MaxLines);
		s.coef_sin = 17'h10000;
		s.coef_cos = 17'h0FFFF;
		apply_settings(s);
		// all four steering slots, start of span clears the pair
		send_pixel(mk_pixel(0, 0, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(0, 1, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(0, 2, 0, 65535, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(0, 3, 0, 65535, PHASE_ID_ONE, 2));
		// second field and odd field lines
		send_pixel(mk_pixel(1, 4, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(2, 5, 65535, 0, PHASE_ID_FOUR, 3));
		send_pixel(mk_pixel(3, 6, 0, 65535, 7, PHASE_ID_FOUR));
		send_pixel(mk_pixel(1023, 1023, 65535, 0, 0, 5));
		send_pixel(mk_pixel(1022, 1022, 0, 65535, 6, 6));
		send_pixel(mk_pixel(512, 0, 40000, 100, 3, PHASE_ID_ONE));
		send_pixel(mk_pixel(513, 1, 32768, 32767, 2, 7));
		// no chroma at all
		send_pixel(mk_pixel(1, 0, 12345, 12345, PHASE_ID_FOUR, PHASE_ID_ONE));
		close_burst();
	endtask

	// two-column, one-line window; pixels on each border
	task automatic test_narrow_window();
		ncqd_cfg_t s;
		s.active_start = 10'd8;
		s.active_end = 11'd10;
		s.first_line = 10'd5;
		s.last_line = 11'd6;
		s.coef_sin = 17'h0FFFF;
		s.coef_cos = 17'h10000;
		apply_settings(s);
		send_pixel(mk_pixel(5, 7, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(5, 8, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(5, 9, 0, 65535, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(5, 10, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(4, 8, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(6, 9, 65535, 0, PHASE_ID_ONE, 2));
		send_pixel(mk_pixel(5, 8, 1000, 30000, 3, PHASE_ID_FOUR));
		close_burst();
	endtask

	// receiver holds off for a long stretch while pixels keep coming
	task automatic test_input_stall();
		ncqd_cfg_t s;
		int col;
		s.active_start = '0;
		s.active_end = 11'(MaxWidth);
		s.first_line = '0;
		s.last_line = 11'(MaxLines);
		s.coef_sin = 17'd8923;
		s.coef_cos = 17'd13741;
		apply_settings(s);
		src_idle = 1'b0;
		snk_idle <= 1'b0;
		stall_req <= stall_req + 1;
		for (col = 0; col < 48; col++)
			send_pixel(mk_pixel(100, col, $urandom_range(0, 65535), $urandom_range(0, 65535),
				PHASE_ID_FOUR, PHASE_ID_ONE));
		close_burst();
	endtask

	// random settings per phase, mostly scanlines with random content
	task automatic test_random_frames();
		ncqd_cfg_t s;
		int sent;
		int n;
		int unsigned pick;
		sent = 0;
		while (sent < 880) begin
			s = random_settings();
			apply_settings(s);
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle <= ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 5)) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) send_scanline(s, 1'b0, n);
				else if (pick < 9) send_noise($urandom_range(3, 10), n);
				else send_scanline(s, 1'b1, n);
				sent += n;
			end
			close_burst();
		end
	endtask

	// receiver side: random gaps, plus the long hold-off on request
	always @(posedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			stall_left = StallCycles;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (snk_idle) snk_gap = pick_gap();
		end
	end

	// every output transaction against the oldest prediction
	always @(posedge clk) begin
		uv_result_t got;
		uv_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = m_tdata;
			if (pending_uv.size() == 0) begin
				$error("unexpected output transaction: luma_out %0d u_out %0d v_out %0d",
					got.luma, got.u, got.v);
				err_count++;
			end else begin
				want = pending_uv.pop_front();
				if (got.luma !== want.luma) begin
					$error("luma_out: expected %0d, actual %0d", want.luma, got.luma);
					err_count++;
				end
				if (got.u !== want.u) begin
					$error("u_out: expected %0d, actual %0d", want.u, got.u);
					err_count++;
				end
				if (got.v !== want.v) begin
					$error("v_out: expected %0d, actual %0d", want.v, got.v);
					err_count++;
				end
			end
		end
	end

	initial begin
		win_cfg = '{active_start: '0, active_end: '0, first_line: '0, last_line: '0,
			coef_sin: '0, coef_cos: CoefCosReset};
		i_hold = '0;
		q_hold = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_full_window();
		test_narrow_window();
		test_input_stall();
		test_random_frames();
		// room for any stray transaction past the pipeline depth
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("ntsc_chroma_quadrature_demod_tb: done, clean");
		else
			$display("ntsc_chroma_quadrature_demod_tb: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("ntsc_chroma_quadrature_demod_tb: done, errors");
		$finish;
	end

endmodule

/* files.f */
sv/ncqd_pkg.sv
sv/ncqd_front.sv
sv/ncqd_queue.sv
sv/ncqd_back.sv
sv/ntsc_chroma_quadrature_demod.sv
test/ntsc_chroma_quadrature_demod_tb.sv
